### hw/rtl/ppmfd_pkg.sv
package ppmfd_pkg;

  typedef enum logic [1:0] {
    EvGoodSync = 2'd0,
    EvBadSync  = 2'd1,
    EvPulse    = 2'd2,
    EvSyncLost = 2'd3
  } event_kind_e;

  typedef enum logic [2:0] {
    CfgSyncMin    = 3'd0,
    CfgSyncMax    = 3'd1,
    CfgPulseMin   = 3'd2,
    CfgPulseMax   = 3'd3,
    CfgFrameMin   = 3'd4,
    CfgFrameMax   = 3'd5,
    CfgGoodNeeded = 3'd6,
    CfgBadNeeded  = 3'd7
  } cfg_idx_e;

  localparam int unsigned TimeW  = 16;
  localparam int unsigned RunW   = 4;
  localparam int unsigned ChanW  = 3;
  localparam int unsigned LevelW = 5;
  localparam int unsigned CfgW   = 16;

  localparam logic [TimeW-1:0] SyncMinRst  = 16'd4000;
  localparam logic [TimeW-1:0] SyncMaxRst  = 16'd22500;
  localparam logic [TimeW-1:0] PulseMinRst = 16'd800;
  localparam logic [TimeW-1:0] PulseMaxRst = 16'd2200;
  localparam logic [TimeW-1:0] FrameMinRst = 16'd18000;
  localparam logic [TimeW-1:0] FrameMaxRst = 16'd27000;
  localparam logic [RunW-1:0]  GoodNeedRst = 4'd2;
  localparam logic [RunW-1:0]  BadNeedRst  = 4'd4;

  // level = min(d / 44, 31); d / 44 = (d >> 2) / 11, and /11 via * 745 >> 13
  localparam int unsigned LevelStep  = 44;
  localparam int unsigned LevelMax   = 31;
  localparam logic [TimeW-1:0] LevelCap = 16'((LevelMax + 1) * LevelStep);
  localparam int unsigned QuotW      = 9;
  localparam int unsigned ProdW      = 19;
  localparam logic [ProdW-1:0] LevelMul = 19'd745;
  localparam int unsigned LevelShift = 13;

  typedef struct packed {
    logic [TimeW-1:0] sync_min;
    logic [TimeW-1:0] sync_max;
    logic [TimeW-1:0] pulse_min;
    logic [TimeW-1:0] pulse_max;
    logic [TimeW-1:0] frame_min;
    logic [TimeW-1:0] frame_max;
    logic [RunW-1:0]  good_needed;
    logic [RunW-1:0]  bad_needed;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] last_edge;
    logic [TimeW-1:0] last_sync;
    logic             sync_held;
    logic [ChanW-1:0] pulses;
    logic [RunW-1:0]  good_run;
    logic [RunW-1:0]  bad_run;
    logic             manual;
  } state_t;

  typedef struct packed {
    event_kind_e       event_kind;
    logic [ChanW-1:0]  channel_index;
    logic [TimeW-1:0]  gap_ticks;
    logic [LevelW-1:0] channel_level;
    logic              link_manual;
    logic [RunW-1:0]   good_count;
    logic [RunW-1:0]   bad_count;
  } result_t;

endpackage

### hw/rtl/ppmfd_if.sv
interface ppmfd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

interface ppmfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [2:0]  channel_index;
  logic [15:0] gap_ticks;
  logic [4:0]  channel_level;
  logic        link_manual;
  logic [3:0]  good_count;
  logic [3:0]  bad_count;

  modport source (output valid, output event_kind, output channel_index, output gap_ticks,
                  output channel_level, output link_manual, output good_count,
                  output bad_count, input ready);
  modport sink   (input valid, input event_kind, input channel_index, input gap_ticks,
                  input channel_level, input link_manual, input good_count,
                  input bad_count, output ready);
endinterface

### hw/rtl/ppmfd_classify.sv
module ppmfd_classify #(
  parameter int unsigned CHANNELS = 5
) (
  input  logic [ppmfd_pkg::TimeW-1:0] capture_time_i,
  input  ppmfd_pkg::cfg_t             cfg_i,
  input  ppmfd_pkg::state_t           state_i,
  output ppmfd_pkg::state_t           state_o,
  output ppmfd_pkg::result_t          result_o
);

  localparam logic [ppmfd_pkg::ChanW-1:0] ChanCnt = ppmfd_pkg::ChanW'(CHANNELS);

  logic [ppmfd_pkg::TimeW-1:0]  gap;
  logic [ppmfd_pkg::TimeW-1:0]  flen;
  logic [ppmfd_pkg::TimeW-1:0]  excess;
  logic [ppmfd_pkg::QuotW-1:0]  quarter;
  logic [ppmfd_pkg::ProdW-1:0]  prod;
  logic [ppmfd_pkg::LevelW-1:0] level;
  logic                         is_sync;
  logic                         is_pulse;
  logic                         frame_ok;
  logic [ppmfd_pkg::RunW-1:0]   good_inc;
  logic [ppmfd_pkg::RunW-1:0]   bad_inc;

  assign gap  = capture_time_i - state_i.last_edge;
  assign flen = capture_time_i - state_i.last_sync;

  assign is_sync  = (gap > cfg_i.sync_min) && (gap < cfg_i.sync_max);
  assign is_pulse = state_i.sync_held && (gap > cfg_i.pulse_min) &&
                    (gap < cfg_i.pulse_max) && (state_i.pulses < ChanCnt);
  assign frame_ok = state_i.sync_held && (flen > cfg_i.frame_min) &&
                    (flen < cfg_i.frame_max) && (state_i.pulses == ChanCnt);

  // quantiser
  assign excess  = gap - cfg_i.pulse_min - ppmfd_pkg::TimeW'(1);
  assign quarter = ppmfd_pkg::QuotW'(excess >> 2);
  assign prod    = ppmfd_pkg::ProdW'(quarter) * ppmfd_pkg::LevelMul;
  assign level   = (excess >= ppmfd_pkg::LevelCap) ? ppmfd_pkg::LevelW'(ppmfd_pkg::LevelMax)
                                                   : ppmfd_pkg::LevelW'(prod >> ppmfd_pkg::LevelShift);

  assign good_inc = (state_i.good_run < cfg_i.good_needed) ? state_i.good_run + 4'd1
                                                           : state_i.good_run;
  assign bad_inc  = (state_i.bad_run < cfg_i.bad_needed) ? state_i.bad_run + 4'd1
                                                         : state_i.bad_run;

  always_comb begin
    state_o                = state_i;
    state_o.last_edge      = capture_time_i;
    result_o.event_kind    = ppmfd_pkg::EvSyncLost;
    result_o.channel_index = '0;
    result_o.channel_level = '0;
    if (is_sync) begin
      state_o.last_sync = capture_time_i;
      state_o.sync_held = 1'b1;
      state_o.pulses    = '0;
      if (frame_ok) begin
        result_o.event_kind = ppmfd_pkg::EvGoodSync;
        state_o.bad_run     = '0;
        state_o.good_run    = good_inc;
        if (good_inc >= cfg_i.good_needed) begin
          state_o.manual = 1'b1;
        end
      end else begin
        result_o.event_kind = ppmfd_pkg::EvBadSync;
        state_o.good_run    = '0;
        state_o.bad_run     = bad_inc;
        if (bad_inc >= cfg_i.bad_needed) begin
          state_o.manual = 1'b0;
        end
      end
    end else if (is_pulse) begin
      result_o.event_kind    = ppmfd_pkg::EvPulse;
      result_o.channel_index = state_i.pulses;
      result_o.channel_level = level;
      state_o.pulses         = state_i.pulses + 3'd1;
    end else begin
      state_o.sync_held = 1'b0;
    end
    result_o.gap_ticks   = gap;
    result_o.link_manual = state_o.manual;
    result_o.good_count  = state_o.good_run;
    result_o.bad_count   = state_o.bad_run;
  end

endmodule

### hw/rtl/ppm_frame_decoder_top.sv
// ppm frame decoder
// cap_i carries one 16-bit timer capture per falling edge of the ppm signal;
// evt_o returns exactly one event per capture, in order: good or bad frame
// sync, channel pulse with index and 5-bit level, or sync lost, plus the gap,
// the link state and both frame run counts after that edge.
// a capture is taken into an input register, classified against the edge
// state and written to the result register; throughput is one capture per
// cycle while evt_o is not stalled.
// the edge state register is updated in the same cycle that the result
// register is loaded, so back-to-back captures see each other's effect.
// the thresholds are written through cfg_we_i / cfg_idx_i / cfg_data_i; the
// user must do so only while no capture is in flight (not enforced here).
// reset restores the default thresholds, clears the edge state and puts the
// link in the no-signal state; the first gap is measured from time zero.
// when evt_o is stalled the result register holds, the input register fills
// and cap_i.ready drops until the receiver takes the waiting result.
module ppm_frame_decoder_top #(
  parameter int unsigned CHANNELS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  ppmfd_in_if.sink    cap_i,
  ppmfd_out_if.source evt_o
);

  ppmfd_pkg::cfg_t                  cfg_q;
  ppmfd_pkg::state_t                state_q;
  ppmfd_pkg::state_t                state_d;
  ppmfd_pkg::result_t               res_d;
  ppmfd_pkg::result_t               out_q;
  logic                             out_valid_q;
  logic                             s1_valid_q;
  logic [ppmfd_pkg::TimeW-1:0]      s1_time_q;
  logic                             out_ready;
  logic                             s1_go;

  assign out_ready   = !out_valid_q || evt_o.ready;
  assign s1_go       = s1_valid_q && out_ready;
  assign cap_i.ready = !s1_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_min    <= ppmfd_pkg::SyncMinRst;
      cfg_q.sync_max    <= ppmfd_pkg::SyncMaxRst;
      cfg_q.pulse_min   <= ppmfd_pkg::PulseMinRst;
      cfg_q.pulse_max   <= ppmfd_pkg::PulseMaxRst;
      cfg_q.frame_min   <= ppmfd_pkg::FrameMinRst;
      cfg_q.frame_max   <= ppmfd_pkg::FrameMaxRst;
      cfg_q.good_needed <= ppmfd_pkg::GoodNeedRst;
      cfg_q.bad_needed  <= ppmfd_pkg::BadNeedRst;
    end else if (cfg_we_i) begin
      case (ppmfd_pkg::cfg_idx_e'(cfg_idx_i))
        ppmfd_pkg::CfgSyncMin:    cfg_q.sync_min    <= cfg_data_i;
        ppmfd_pkg::CfgSyncMax:    cfg_q.sync_max    <= cfg_data_i;
        ppmfd_pkg::CfgPulseMin:   cfg_q.pulse_min   <= cfg_data_i;
        ppmfd_pkg::CfgPulseMax:   cfg_q.pulse_max   <= cfg_data_i;
        ppmfd_pkg::CfgFrameMin:   cfg_q.frame_min   <= cfg_data_i;
        ppmfd_pkg::CfgFrameMax:   cfg_q.frame_max   <= cfg_data_i;
        ppmfd_pkg::CfgGoodNeeded: cfg_q.good_needed <= cfg_data_i[3:0];
        ppmfd_pkg::CfgBadNeeded:  cfg_q.bad_needed  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cap_i.ready) begin
      s1_valid_q <= cap_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_i.valid && cap_i.ready) begin
      s1_time_q <= cap_i.capture_time;
    end
  end

  ppmfd_classify #(
    .CHANNELS (CHANNELS)
  ) u_classify (
    .capture_time_i (s1_time_q),
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_go) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_q <= res_d;
    end
  end

  assign evt_o.valid         = out_valid_q;
  assign evt_o.event_kind    = out_q.event_kind;
  assign evt_o.channel_index = out_q.channel_index;
  assign evt_o.gap_ticks     = out_q.gap_ticks;
  assign evt_o.channel_level = out_q.channel_level;
  assign evt_o.link_manual   = out_q.link_manual;
  assign evt_o.good_count    = out_q.good_count;
  assign evt_o.bad_count     = out_q.bad_count;

`ifndef SYNTH
  a_pulses_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pulses <= 3'(CHANNELS))
    else $error("pulse count beyond channel count");

  a_runs_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.good_run != '0 && state_q.bad_run != '0))
    else $error("good and bad runs both non-zero");

  a_lost_clears_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && res_d.event_kind == ppmfd_pkg::EvSyncLost |=> !state_q.sync_held)
    else $error("sync still held after sync lost");

  a_non_pulse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.event_kind != ppmfd_pkg::EvPulse |->
      out_q.channel_index == '0 && out_q.channel_level == '0)
    else $error("channel fields set on a non-pulse event");
`endif

endmodule
